@@ hdl/idr_pkg.sv @@
// Shared types, widths and helpers for the pipelined integer divider.
// Used by every module under hdl; depends on nothing else.
package idr_pkg;

	localparam int WORD_BITS = 32;
	localparam int STEPS     = WORD_BITS;

	typedef struct packed {
		logic                 enable_op;
		logic                 signed_mode;
		logic [WORD_BITS-1:0] dividend;
		logic [WORD_BITS-1:0] divisor;
	} idr_in_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] quotient;
		logic [WORD_BITS-1:0] remainder;
	} idr_out_t;

	typedef struct packed {
		logic                 valid;
		logic                 neg_q;
		logic                 neg_r;
		logic [WORD_BITS-1:0] rem;
		logic [WORD_BITS-1:0] quo;
		logic [WORD_BITS-1:0] dvs;
	} idr_stage_t;

	function automatic logic [WORD_BITS-1:0] twos_neg(input logic [WORD_BITS-1:0] v);
		return ~v + {{(WORD_BITS-1){1'b0}}, 1'b1};
	endfunction

endpackage

@@ hdl/idr_pre.sv @@
// Operand conditioning stage: magnitudes and result sign flags.
// Depends on idr_pkg.
module idr_pre import idr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic       req_valid,
	input  idr_in_t    req,
	output idr_stage_t stage_out
);

	logic       neg_a;
	logic       neg_b;
	logic       dvs_zero;
	idr_stage_t stage_d;
	idr_stage_t stage_s1;

	always_comb begin
		neg_a    = req.signed_mode & req.dividend[WORD_BITS-1];
		neg_b    = req.signed_mode & req.divisor[WORD_BITS-1];
		dvs_zero = (req.divisor == '0);
		stage_d.valid = req_valid & req.enable_op;
		stage_d.neg_q = (neg_a ^ neg_b) & ~dvs_zero;
		stage_d.neg_r = neg_a;
		stage_d.rem   = '0;
		stage_d.quo   = neg_a ? twos_neg(req.dividend) : req.dividend;
		stage_d.dvs   = neg_b ? twos_neg(req.divisor) : req.divisor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (advance) begin
			stage_s1 <= stage_d;
		end
	end

	assign stage_out = stage_s1;

endmodule

@@ hdl/idr_step.sv @@
// One restoring division step: one quotient bit per register stage.
// Depends on idr_pkg.
module idr_step import idr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  idr_stage_t stage_in,
	output idr_stage_t stage_out
);

	logic [WORD_BITS:0] part;
	logic [WORD_BITS:0] diff;
	logic               fit;
	idr_stage_t         stage_d;
	idr_stage_t         stage_s1;

	always_comb begin
		part = {stage_in.rem, stage_in.quo[WORD_BITS-1]};
		diff = part - {1'b0, stage_in.dvs};
		fit  = ~diff[WORD_BITS];
		stage_d       = stage_in;
		stage_d.rem   = fit ? diff[WORD_BITS-1:0] : part[WORD_BITS-1:0];
		stage_d.quo   = {stage_in.quo[WORD_BITS-2:0], fit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (advance) begin
			stage_s1 <= stage_d;
		end
	end

	assign stage_out = stage_s1;

endmodule

@@ hdl/idr_post.sv @@
// Sign correction of quotient and remainder, and the output register.
// Depends on idr_pkg.
module idr_post import idr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  idr_stage_t stage_in,
	output logic       rsp_valid,
	output idr_out_t   rsp
);

	idr_out_t rsp_d;
	logic     valid_s1;
	idr_out_t rsp_s1;

	always_comb begin
		rsp_d.quotient  = stage_in.neg_q ? twos_neg(stage_in.quo) : stage_in.quo;
		rsp_d.remainder = stage_in.neg_r ? twos_neg(stage_in.rem) : stage_in.rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= stage_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s1 <= rsp_d;
		end
	end

	assign rsp_valid = valid_s1;
	assign rsp       = rsp_s1;

endmodule

@@ hdl/integer_divide_remainder_core.sv @@
// Pipelined integer divider, quotient and remainder with RISC-V M-extension results.
// Depends on idr_pkg, idr_pre, idr_step and idr_post.
//
// Request channel req_valid/req_ready carries an idr_in_t word; a word is taken
// when both are high. A word with enable_op clear is taken and gives no response.
// Response channel rsp_valid/rsp_ready carries an idr_out_t word.
// A word passes WORD_BITS + 2 register stages on its way to rsp: one operand
// stage, one stage per quotient bit, one sign stage.
// Throughput: one request per cycle while rsp is not stalled; each quotient bit
// has its own subtractor.
// Divide by zero gives an all-ones quotient and the dividend as remainder; the
// most negative value divided by -1 gives the dividend and a zero remainder.
// Reset clears every stage valid bit; no response is pending afterwards.
// When rsp_valid is high and rsp_ready low, the whole pipeline holds and
// req_ready drops in the same cycle; nothing is lost or repeated.
module integer_divide_remainder_core import idr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  idr_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output idr_out_t rsp
);

	logic       advance;
	idr_stage_t pipe [STEPS+1];

	assign advance   = ~rsp_valid | rsp_ready;
	assign req_ready = advance;

	idr_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.req_valid (req_valid),
		.req       (req),
		.stage_out (pipe[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		idr_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.stage_in  (pipe[i]),
			.stage_out (pipe[i+1])
		);
	end

	idr_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.stage_in  (pipe[STEPS]),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		pipe[STEPS].valid && pipe[STEPS].dvs != '0 |-> pipe[STEPS].rem < pipe[STEPS].dvs)
		else $error("partial remainder not below divisor at last step");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pipe[STEPS].valid) && $stable(pipe[0].valid))
		else $error("pipeline moved during stall");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pipe[STEPS].valid && pipe[STEPS].dvs == '0
		|=> rsp_valid && rsp.quotient == '1)
		else $error("divide by zero quotient not all ones");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pipe[STEPS].valid |=> rsp_valid)
		else $error("last stage word not moved to output");
`endif

endmodule
